[hdl/zpd_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// zpd_pkg: shared definitions for the single-wire pulse decoder
// Widths, reset values of the limit registers, status and register codes.
// ---------------------------------------------------------------------------
package zpd_pkg;

   localparam int unsigned WIDTH_W         = 16;   // pulse width field
   localparam int unsigned RAW_W           = 16;   // assembled frame value
   localparam int unsigned POS_W           = 5;    // bit position counter
   localparam int unsigned TEMP_W          = 11;   // signed tenths of a degree
   localparam int unsigned CSR_INDEX_W     = 2;

   localparam int unsigned LAST_POSITION   = 16;
   localparam int unsigned PARITY_POSITION = 8;

   localparam logic [WIDTH_W-1:0] ONE_LIMIT_RST    = 16'd50;
   localparam logic [WIDTH_W-1:0] STROBE_LIMIT_RST = 16'd70;
   localparam logic [WIDTH_W-1:0] ERROR_LIMIT_RST  = 16'd150;

   // Scaling: value * 700 / 2047 - 100, where 2047 = 2**11 - 1
   localparam int unsigned SCALE_MUL   = 700;
   localparam int unsigned SCALE_SHIFT = 11;
   localparam int unsigned RAW_MAX     = (1 << SCALE_SHIFT) - 1;
   localparam int unsigned TEMP_OFFSET = 100;
   localparam int unsigned PROD_W      = 21;       // 2047 * 700 < 2**21

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_PULSE_ERR = 2'd1,
      ST_RANGE_ERR = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONE_LIMIT    = 2'd0,
      CSR_STROBE_LIMIT = 2'd1,
      CSR_ERROR_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_PULSE = 1'b1
   } kind_type;

endpackage
`default_nettype wire

[hdl/zacwire_pulse_decoder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// zacwire_pulse_decoder: single-wire temperature sensor frame decoder
// Classifies captured low-pulse widths into bits, assembles the frame and
// reports the raw value with the temperature in tenths of a degree.
// ---------------------------------------------------------------------------
//  channel   direction  tdata / data                         tuser / index
//  req_      in         [15:0] pulse_width                   [0] kind
//  rsp_      out        [15:0] raw_value, [26:16] temp       [1:0] status
//  csr_      in         [15:0] limit value                   [1:0] register
//
//  A word is taken into the input register, then the decode logic updates the
//  state and, at a frame's end, the result register; one word per cycle unless stalled.
//  Throughput is set by the result register; it stalls only on rsp_tready.
//  Reset is synchronous; limits return to 50 / 70 / 150 and the decoder idles.
//  While a result waits, one more word is still taken into the input register.
// ---------------------------------------------------------------------------
module zacwire_pulse_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [zpd_pkg::WIDTH_W-1:0]        req_tdata,   // [15:0] pulse_width
   input  wire logic                               req_tuser,   // [0] kind

   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [31:0]                             rsp_tdata,   // [15:0] raw_value,
                                                                // [26:16] temperature_tenths
   output logic [1:0]                              rsp_tuser,   // [1:0] status

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [zpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [zpd_pkg::WIDTH_W-1:0]        csr_data
);
   import zpd_pkg::*;

   // input register
   logic                        in_valid_ff;
   logic                        in_kind_ff;
   logic [WIDTH_W-1:0]          in_width_ff;

   // limits
   logic [WIDTH_W-1:0]          one_limit_ff;
   logic [WIDTH_W-1:0]          strobe_limit_ff;
   logic [WIDTH_W-1:0]          error_limit_ff;

   // decoder state
   logic                        armed_ff,  armed_in;
   logic [POS_W-1:0]            pos_ff,    pos_in;
   logic [RAW_W-1:0]            shift_ff,  shift_in;

   // result register
   logic                        rsp_valid_ff;
   status_type                  rsp_status_ff, rsp_status_in;
   logic [RAW_W-1:0]            rsp_raw_ff,    rsp_raw_in;
   logic signed [TEMP_W-1:0]    rsp_temp_ff,   rsp_temp_in;

   logic                        advance;
   logic                        rsp_load;
   logic [RAW_W-1:0]            shift_cand;
   logic signed [TEMP_W-1:0]    temp_scaled;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign shift_cand = shift_ff | RAW_W'(in_width_ff < one_limit_ff);

   zpd_scale u_scale (
      .raw_value          (shift_cand[SCALE_SHIFT-1:0]),
      .temperature_tenths (temp_scaled)
   );

   always_comb begin
      armed_in      = armed_ff;
      pos_in        = pos_ff;
      shift_in      = shift_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_raw_in    = shift_cand;
      rsp_temp_in   = '0;
      if (kind_type'(in_kind_ff) == KIND_START) begin
         armed_in = 1'b1;
         pos_in   = '0;
         shift_in = '0;
      end else if (armed_ff) begin
         if (pos_ff == POS_W'(PARITY_POSITION)) begin
            pos_in = pos_ff + 1'b1;               // skip parity bit
         end else if (in_width_ff > error_limit_ff) begin
            armed_in      = 1'b0;
            rsp_load      = 1'b1;
            rsp_status_in = ST_PULSE_ERR;
            rsp_raw_in    = '0;
         end else if (in_width_ff < one_limit_ff || in_width_ff >= strobe_limit_ff) begin
            if (pos_ff == POS_W'(LAST_POSITION)) begin
               armed_in = 1'b0;
               shift_in = shift_cand;
               rsp_load = 1'b1;
               if (shift_cand > RAW_W'(RAW_MAX)) begin
                  rsp_status_in = ST_RANGE_ERR;
               end else begin
                  rsp_temp_in = temp_scaled;
               end
            end else begin
               pos_in   = pos_ff + 1'b1;
               shift_in = {shift_cand[RAW_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff  <= req_tuser;
         in_width_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_limit_ff    <= ONE_LIMIT_RST;
         strobe_limit_ff <= STROBE_LIMIT_RST;
         error_limit_ff  <= ERROR_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ONE_LIMIT:    one_limit_ff    <= csr_data;
            CSR_STROBE_LIMIT: strobe_limit_ff <= csr_data;
            CSR_ERROR_LIMIT:  error_limit_ff  <= csr_data;
            default: ;                            // drop writes to unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         pos_ff   <= '0;
         shift_ff <= '0;
      end else if (advance) begin
         armed_ff <= armed_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_raw_ff    <= rsp_raw_in;
         rsp_temp_ff   <= rsp_temp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_temp_ff, rsp_raw_ff};
   assign rsp_tuser  = rsp_status_ff;

   // a finished frame never carries a value outside the sensor range
   a_done_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_DONE |->
         rsp_raw_ff <= RAW_W'(RAW_MAX) &&
         rsp_temp_ff >= $signed(-TEMP_W'(TEMP_OFFSET)) &&
         rsp_temp_ff <= $signed(TEMP_W'(SCALE_MUL - TEMP_OFFSET)))
      else $error("done result out of range");

   a_err_zero_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_DONE |-> rsp_temp_ff == '0)
      else $error("error result carries a temperature");

   // the decoder disarms only when it hands out a result
   a_disarm_with_result: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $fell(armed_ff) |-> $past(advance && rsp_load))
      else $error("decoder disarmed without a result");

   // a held input word is not overwritten
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_width_ff) && $stable(in_kind_ff))
      else $error("input register lost a word");

endmodule
`default_nettype wire

[hdl/zpd_scale.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// zpd_scale: raw frame value to tenths of a degree
// Computes value * 700 / 2047 - 100 with truncation for values up to 2047.
// Division by 2**11 - 1 uses a shift, an end-around add and one correction.
// ---------------------------------------------------------------------------
module zpd_scale (
   input  wire logic        [zpd_pkg::SCALE_SHIFT-1:0] raw_value,
   output logic signed      [zpd_pkg::TEMP_W-1:0]      temperature_tenths
);
   import zpd_pkg::*;

   localparam int unsigned Q_W = PROD_W - SCALE_SHIFT;

   logic [PROD_W-1:0]      prod;
   logic [Q_W-1:0]         q_hi;
   logic [SCALE_SHIFT:0]   rem;
   logic [Q_W-1:0]         quot;

   always_comb begin
      prod = PROD_W'(raw_value) * PROD_W'(SCALE_MUL);
      q_hi = prod[PROD_W-1:SCALE_SHIFT];
      // x mod (2**n - 1) folds as low part plus high part; stays below twice the divisor
      rem  = (SCALE_SHIFT+1)'(prod[SCALE_SHIFT-1:0]) + (SCALE_SHIFT+1)'(q_hi);
      quot = q_hi + Q_W'(rem >= (SCALE_SHIFT+1)'(RAW_MAX));
      temperature_tenths = $signed(TEMP_W'(quot)) - $signed(TEMP_W'(TEMP_OFFSET));
   end

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the single-wire pulse frame decoder
// Drives start and pulse-width words, mirrors the decoder in a local model,
// and checks every result word in order while both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;

   import zpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned SETTLE_WAIT  = 6;      // pipeline is two words deep
   localparam int unsigned HOLD_OFF     = 400;
   localparam int unsigned PHASE_ITEMS  = 85;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef enum logic [1:0] {
      PULSE_ERROR,
      PULSE_ONE,
      PULSE_STROBE,
      PULSE_ZERO
   } pulse_class_type;

   typedef struct packed {
      status_type          status;
      logic [RAW_W-1:0]    raw_value;
      logic [TEMP_W-1:0]   temperature;
   } frame_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [WIDTH_W-1:0]        req_tdata = '0;
   logic                      req_tuser = KIND_START;

   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;
   logic [1:0]                rsp_tuser;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index = CSR_ONE_LIMIT;
   logic [WIDTH_W-1:0]        csr_data = '0;

   // local copy of decoder state and limits
   logic [WIDTH_W-1:0]        one_limit    = ONE_LIMIT_RST;
   logic [WIDTH_W-1:0]        strobe_limit = STROBE_LIMIT_RST;
   logic [WIDTH_W-1:0]        error_limit  = ERROR_LIMIT_RST;
   logic [RAW_W-1:0]          shift_value  = '0;
   logic [POS_W-1:0]          bit_position = '0;
   logic                      armed        = 1'b0;

   frame_result_type          expected_frames[$];
   frame_result_type          exp_frame;

   int unsigned               send_idle_pct = 0;
   int unsigned               recv_idle_pct = 0;
   int unsigned               hold_cycles   = 0;
   int unsigned               words_sent    = 0;
   int unsigned               fail_count    = 0;
   int unsigned               cycle_count   = 0;

   zacwire_pulse_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random idling, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker: compare each word with the oldest expected frame
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: status %0d raw %h temp %0d",
                        rsp_tuser, rsp_tdata[15:0], $signed(rsp_tdata[26:16]));
         end else begin
            exp_frame = expected_frames.pop_front();
            if (rsp_tuser != exp_frame.status || rsp_tdata[15:0] != exp_frame.raw_value ||
                rsp_tdata[26:16] != exp_frame.temperature || rsp_tdata[31:27] != '0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch: status %0d/%0d raw %h/%h temp %0d/%0d pad %h",
                           exp_frame.status, rsp_tuser, exp_frame.raw_value,
                           rsp_tdata[15:0], $signed(exp_frame.temperature),
                           $signed(rsp_tdata[26:16]), rsp_tdata[31:27]);
            end
         end
      end
   end

   function automatic pulse_class_type classify_width(logic [WIDTH_W-1:0] w);
      // error limit first, then one, then strobe, regardless of ordering
      if (w > error_limit)
         return PULSE_ERROR;
      else if (w < one_limit)
         return PULSE_ONE;
      else if (w < strobe_limit)
         return PULSE_STROBE;
      return PULSE_ZERO;
   endfunction

   function automatic void decode_word(kind_type kind, logic [WIDTH_W-1:0] w);
      frame_result_type r;
      pulse_class_type  c;
      logic [31:0]      scaled;
      if (kind == KIND_START) begin
         shift_value  = '0;
         bit_position = '0;
         armed        = 1'b1;
         return;
      end
      if (!armed)
         return;
      // parity slot is skipped before any width test
      if (bit_position == PARITY_POSITION) begin
         bit_position = bit_position + 1'b1;
         return;
      end
      c = classify_width(w);
      if (c == PULSE_ERROR) begin
         armed         = 1'b0;
         r.status      = ST_PULSE_ERR;
         r.raw_value   = '0;
         r.temperature = '0;
         expected_frames.push_back(r);
         return;
      end
      if (c == PULSE_STROBE)
         return;
      if (c == PULSE_ONE)
         shift_value[0] = 1'b1;
      if (bit_position == LAST_POSITION) begin
         armed       = 1'b0;
         r.raw_value = shift_value;
         if (shift_value > RAW_MAX) begin
            r.status      = ST_RANGE_ERR;
            r.temperature = '0;
         end else begin
            scaled        = shift_value * SCALE_MUL / RAW_MAX - TEMP_OFFSET;
            r.status      = ST_DONE;
            r.temperature = scaled[TEMP_W-1:0];
         end
         expected_frames.push_back(r);
         return;
      end
      bit_position = bit_position + 1'b1;
      shift_value  = shift_value << 1;
   endfunction

   function automatic logic [WIDTH_W-1:0] random_width();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return one_limit - 1'b1 + WIDTH_W'($urandom_range(2));
         3:       return strobe_limit - 1'b1 + WIDTH_W'($urandom_range(2));
         4:       return error_limit - 1'b1 + WIDTH_W'($urandom_range(2));
         5:       return WIDTH_W'($urandom_range(255));
         default: return WIDTH_W'($urandom);
      endcase
   endfunction

   // find a width of the wanted class; keep the last try if none fits
   function automatic logic [WIDTH_W-1:0] width_of_class(pulse_class_type c);
      logic [WIDTH_W-1:0] w;
      w = random_width();
      for (int i = 0; i < 16 && classify_width(w) != c; i++)
         w = random_width();
      return w;
   endfunction

   function automatic logic [RAW_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return '0;
         1:       return RAW_W'(RAW_MAX);
         2:       return RAW_W'(RAW_MAX + 1);
         3:       return '1;
         4:       return RAW_W'($urandom);
         default: return RAW_W'($urandom_range(RAW_MAX));
      endcase
   endfunction

   task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
   endtask

   task automatic send_word(kind_type kind, logic [WIDTH_W-1:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      decode_word(kind, w);
      words_sent++;
   endtask

   // start, then data bits MSB first with the parity slot in between
   task automatic send_frame(logic [RAW_W-1:0] value, bit with_strobes);
      int unsigned data_index;
      data_index = 0;
      send_word(KIND_START, WIDTH_W'($urandom));
      for (int unsigned pos = 0; pos <= LAST_POSITION; pos++) begin
         if (pos == PARITY_POSITION) begin
            send_word(KIND_PULSE, random_width());
         end else begin
            if (with_strobes && $urandom_range(9) == 0)
               send_word(KIND_PULSE, width_of_class(PULSE_STROBE));
            send_word(KIND_PULSE,
                      width_of_class(value[RAW_W-1-data_index] ? PULSE_ONE : PULSE_ZERO));
            data_index++;
         end
      end
   endtask

   // drop valid, drain all results, then let the pipeline settle
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type index, logic [WIDTH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         CSR_ONE_LIMIT:    one_limit    = value;
         CSR_STROBE_LIMIT: strobe_limit = value;
         CSR_ERROR_LIMIT:  error_limit  = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_limits(logic [WIDTH_W-1:0] one, logic [WIDTH_W-1:0] strobe,
                               logic [WIDTH_W-1:0] err);
      finish_phase();
      write_reg(CSR_ONE_LIMIT, one);
      write_reg(CSR_STROBE_LIMIT, strobe);
      write_reg(CSR_ERROR_LIMIT, err);
   endtask

   task automatic test_directed();
      // pulses while idle are dropped
      send_word(KIND_PULSE, '0);
      send_word(KIND_PULSE, '1);
      // restart in the middle of a frame
      send_word(KIND_START, '1);
      send_word(KIND_PULSE, '0);
      send_word(KIND_START, '0);
      // strobe, zero at the error limit, then one past it
      send_word(KIND_PULSE, 16'd60);
      send_word(KIND_PULSE, ERROR_LIMIT_RST);
      send_word(KIND_PULSE, ERROR_LIMIT_RST + 1'b1);
      send_word(KIND_PULSE, '0);
      // overlong parity pulse is skipped; all ones gives a range error
      send_word(KIND_START, '0);
      for (int unsigned pos = 0; pos <= LAST_POSITION; pos++)
         send_word(KIND_PULSE, (pos == PARITY_POSITION) ? '1 : '0);
      finish_phase();
   endtask

   task automatic run_random_phase(int unsigned count);
      int unsigned target;
      int unsigned roll;
      int unsigned burst;
      target = words_sent + count;
      while (words_sent < target) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            send_frame(pick_value(), 1'b1);
         end else if (roll < 88) begin
            // broken frame: start and a short run of arbitrary pulses
            burst = $urandom_range(20);
            send_word(KIND_START, WIDTH_W'($urandom));
            repeat (burst) send_word(KIND_PULSE, random_width());
         end else begin
            send_word(kind_type'($urandom_range(1)), random_width());
         end
      end
      finish_phase();
   endtask

   task automatic test_limit_settings();
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       set_idling(9, 81);
            1:       set_idling(81, 9);
            default: set_idling(0, 0);
         endcase
         write_limits(ONE_LIMIT_RST, STROBE_LIMIT_RST, ERROR_LIMIT_RST);
         run_random_phase(PHASE_ITEMS);
         write_limits('0, '0, '0);
         run_random_phase(PHASE_ITEMS);
         write_limits('1, '1, '1);
         run_random_phase(PHASE_ITEMS);
         // limits out of ascending order
         write_limits(16'd120, 16'd40, 16'd90);
         run_random_phase(PHASE_ITEMS);
         write_limits(WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
         run_random_phase(PHASE_ITEMS);
      end
   endtask

   // hold the receiver while frames keep coming so the input stalls
   task automatic test_backpressure();
      set_idling(0, 0);
      write_limits(ONE_LIMIT_RST, STROBE_LIMIT_RST, ERROR_LIMIT_RST);
      hold_cycles = HOLD_OFF;
      repeat (4) send_frame(RAW_W'($urandom_range(RAW_MAX)), 1'b0);
      finish_phase();
   endtask

   initial begin
      set_idling(9, 81);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limit_settings();
      test_backpressure();
      finish_phase();
      if (fail_count == 0 && expected_frames.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
